FILE: rtl/linear_probe_hash_table_core_macros.svh
// Assertion macros for the linear probe hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`ifndef SYNTH
`define LPHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht: same-cycle check failed");
`define LPHT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht: next-cycle check failed");
`else
`define LPHT_ASSERT_IMP(label, ante, cons)
`define LPHT_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/lpht_pkg.sv
// Shared types, codes and constants of the linear probe hash table.
package lpht_pkg;

  // Default sizes handed to the top level parameters.
  localparam int SLOTS_DEF      = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // Widest slot index over the supported table sizes.
  localparam int IDX_MAX_W = 16;

  // Entries of the queue between front and back end (a power of two).
  localparam int Q_DEPTH = 2;

  // Load limit after reset.
  localparam logic [7:0] LOAD_LIMIT_RST = 8'd192;

  // Request codes.
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Slot status codes.
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  typedef logic [IDX_MAX_W-1:0] home_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic        full_res;
  } out_item_t;

  // A classified request waiting for the back end.
  typedef struct packed {
    logic [1:0]  opcode;
    logic        op_ok;
    logic [31:0] key_id;
    logic [63:0] value_in;
    home_t       home;
  } q_entry_t;

endpackage

FILE: rtl/lpht_front.sv
// Front end: accepts requests, decodes the opcode and reduces the hash to a home slot.
module lpht_front #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lpht_pkg::in_item_t  in_data,
  output logic                in_stall,
  output logic                push_valid,
  output lpht_pkg::q_entry_t  push_data,
  input  logic                push_stall
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int SHIFT   = 32 + IDX_W;
  localparam int RECIP_W = 33;
  localparam int PROD_W  = 32 + RECIP_W;
  // Rounded-up reciprocal: (hash * RECIP) >> SHIFT is exactly hash / SLOTS.
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  typedef logic [IDX_W-1:0] idx_t;

  logic               s1_valid_r;
  lpht_pkg::in_item_t s1_item_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic               s2_valid_r;
  lpht_pkg::q_entry_t s2_entry_r;

  logic               s2_load_ok;
  logic               s1_load_ok;
  logic               in_fire;
  logic               s1_adv;
  logic [PROD_W-1:0]  prod_nxt;
  idx_t               quot_lo;
  idx_t               quot_slots;
  idx_t               home;
  logic               op_ok;

  // Stage handshakes: a stage loads when it is empty or moves on this cycle.
  assign s2_load_ok = !s2_valid_r || !push_stall;
  assign s1_adv     = s1_valid_r && s2_load_ok;
  assign s1_load_ok = !s1_valid_r || s2_load_ok;
  assign in_stall   = !s1_load_ok;
  assign in_fire    = in_valid && s1_load_ok;

  // Stage one multiplies the hash by the reciprocal of the table size.
  assign prod_nxt = PROD_W'(in_data.key_hash) * PROD_W'(RECIP[RECIP_W-1:0]);

  // Stage two forms the remainder; only its low index bits are needed.
  assign quot_lo    = s1_prod_r[SHIFT +: IDX_W];
  assign quot_slots = idx_t'(quot_lo * idx_t'(SLOTS));
  assign home       = idx_t'(s1_item_r.key_hash[IDX_W-1:0] - quot_slots);

  // Classify the opcode; the unused code skips the probe.
  assign op_ok = s1_item_r.opcode inside {lpht_pkg::OP_GET, lpht_pkg::OP_SET,
                                          lpht_pkg::OP_REMOVE};

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_load_ok) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load_ok) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
      s1_prod_r <= prod_nxt;
    end
    if (s1_adv) begin
      s2_entry_r.opcode   <= s1_item_r.opcode;
      s2_entry_r.op_ok    <= op_ok;
      s2_entry_r.key_id   <= s1_item_r.key_id;
      s2_entry_r.value_in <= s1_item_r.value_in;
      s2_entry_r.home     <= lpht_pkg::home_t'(home);
    end
  end

  assign push_valid = s2_valid_r;
  assign push_data  = s2_entry_r;

endmodule

FILE: rtl/lpht_queue.sv
// Short request queue between the front and back end.
module lpht_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  lpht_pkg::q_entry_t  push_data,
  output logic                push_stall,
  output logic                pop_valid,
  output lpht_pkg::q_entry_t  pop_data,
  input  logic                pop_req
);

  localparam int PTR_W = $clog2(lpht_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(lpht_pkg::Q_DEPTH + 1);

  lpht_pkg::q_entry_t entry_r [lpht_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;

  assign push_stall = (count_r == CNT_W'(lpht_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_req && pop_valid;
  assign pop_data   = entry_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/lpht_back.sv
// Back end: probes the slot memories, applies the request and holds the result.
module lpht_back #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                pop_valid,
  input  lpht_pkg::q_entry_t  pop_data,
  output logic                pop_req,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::out_item_t out_data
);

  `include "linear_probe_hash_table_core_macros.svh"

  localparam int IDX_W = $clog2(SLOTS);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  localparam idx_t LAST_IDX = idx_t'(SLOTS - 1);

  typedef enum logic [3:0] {
    BS_CLEAR = 4'b0001,
    BS_IDLE  = 4'b0010,
    BS_PROBE = 4'b0100,
    BS_DONE  = 4'b1000
  } back_state_t;

  // Slot memories.
  logic [1:0] status_mem [SLOTS];
  key_t       key_mem    [SLOTS];
  val_t       value_mem  [SLOTS];

  back_state_t         state_r, state_nxt;
  lpht_pkg::q_entry_t  cur_r, cur_nxt;
  idx_t                idx_r, idx_nxt;
  idx_t                steps_r, steps_nxt;
  idx_t                clr_idx_r, clr_idx_nxt;
  logic                tomb_seen_r, tomb_seen_nxt;
  idx_t                tomb_idx_r, tomb_idx_nxt;
  logic                found_r, found_nxt;
  idx_t                where_r, where_nxt;
  logic                where_ok_r, where_ok_nxt;
  logic                where_tomb_r, where_tomb_nxt;
  val_t                hit_val_r, hit_val_nxt;
  logic [7:0]          occ_r, occ_nxt;
  logic [7:0]          limit_r;
  logic                out_valid_r, out_valid_nxt;
  lpht_pkg::out_item_t out_data_r, out_data_nxt;

  logic [1:0] st_rd_r;
  key_t       key_rd_r;
  val_t       val_rd_r;

  logic       st_we;
  logic [1:0] st_wdata;
  logic       key_we;
  logic       val_we;
  idx_t       wr_addr;

  key_t       cur_key;
  val_t       cur_val;
  logic       out_free;
  logic       rd_empty;
  logic       rd_live;
  logic       tomb_new;
  logic       tomb_seen_u;
  idx_t       tomb_idx_u;
  logic [8:0] occ_inc;

  assign cur_key  = key_t'(cur_r.key_id);
  assign cur_val  = val_t'(cur_r.value_in);
  assign out_free = !out_valid_r || !out_stall;
  assign rd_empty = (st_rd_r == lpht_pkg::ST_EMPTY);
  assign rd_live  = (st_rd_r == lpht_pkg::ST_LIVE);

  // The first tombstone on the probe path is kept for reuse.
  assign tomb_new    = !rd_empty && !rd_live && !tomb_seen_r;
  assign tomb_seen_u = tomb_seen_r || tomb_new;
  assign tomb_idx_u  = tomb_new ? idx_r : tomb_idx_r;
  assign occ_inc     = {1'b0, occ_r} + 9'd1;

  // Sequencer: dequeue, probe one slot a cycle, then commit and emit.
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    clr_idx_nxt    = clr_idx_r;
    tomb_seen_nxt  = tomb_seen_r;
    tomb_idx_nxt   = tomb_idx_r;
    found_nxt      = found_r;
    where_nxt      = where_r;
    where_ok_nxt   = where_ok_r;
    where_tomb_nxt = where_tomb_r;
    hit_val_nxt    = hit_val_r;
    occ_nxt        = occ_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pop_req        = 1'b0;
    st_we          = 1'b0;
    st_wdata       = lpht_pkg::ST_EMPTY;
    key_we         = 1'b0;
    val_we         = 1'b0;
    wr_addr        = where_r;

    case (state_r)
      BS_CLEAR: begin
        st_we       = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + idx_t'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_IDLE: begin
        pop_req = pop_valid;
        if (pop_valid) begin
          cur_nxt        = pop_data;
          idx_nxt        = idx_t'(pop_data.home);
          steps_nxt      = '0;
          tomb_seen_nxt  = 1'b0;
          tomb_idx_nxt   = '0;
          found_nxt      = 1'b0;
          where_nxt      = '0;
          where_ok_nxt   = 1'b0;
          where_tomb_nxt = 1'b0;
          state_nxt      = pop_data.op_ok ? BS_PROBE : BS_DONE;
        end
      end
      BS_PROBE: begin
        if (rd_empty) begin
          // An empty slot ends the probe: insert at the first tombstone or here.
          found_nxt      = 1'b0;
          where_nxt      = tomb_seen_r ? tomb_idx_r : idx_r;
          where_ok_nxt   = 1'b1;
          where_tomb_nxt = tomb_seen_r;
          state_nxt      = BS_DONE;
        end else if (rd_live && (key_rd_r == cur_key)) begin
          found_nxt   = 1'b1;
          where_nxt   = idx_r;
          hit_val_nxt = val_rd_r;
          state_nxt   = BS_DONE;
        end else if (steps_r == LAST_IDX) begin
          // Whole table visited without an empty slot or the key.
          found_nxt      = 1'b0;
          tomb_seen_nxt  = tomb_seen_u;
          tomb_idx_nxt   = tomb_idx_u;
          where_nxt      = tomb_idx_u;
          where_ok_nxt   = tomb_seen_u;
          where_tomb_nxt = 1'b1;
          state_nxt      = BS_DONE;
        end else begin
          tomb_seen_nxt = tomb_seen_u;
          tomb_idx_nxt  = tomb_idx_u;
          steps_nxt     = steps_r + idx_t'(1);
          idx_nxt       = (idx_r == LAST_IDX) ? '0 : idx_r + idx_t'(1);
        end
      end
      BS_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.hit       = found_r;
          out_data_nxt.value_out = '0;
          out_data_nxt.full_res  = 1'b0;
          state_nxt              = BS_IDLE;
          case (cur_r.opcode)
            lpht_pkg::OP_GET: begin
              if (found_r) begin
                out_data_nxt.value_out = 64'(hit_val_r);
              end
            end
            lpht_pkg::OP_SET: begin
              if (found_r) begin
                val_we = 1'b1;
              end else if (!where_ok_r) begin
                out_data_nxt.full_res = 1'b1;
              end else if (where_tomb_r) begin
                st_we    = 1'b1;
                st_wdata = lpht_pkg::ST_LIVE;
                key_we   = 1'b1;
                val_we   = 1'b1;
              end else if (occ_inc > {1'b0, limit_r}) begin
                out_data_nxt.full_res = 1'b1;
              end else begin
                st_we    = 1'b1;
                st_wdata = lpht_pkg::ST_LIVE;
                key_we   = 1'b1;
                val_we   = 1'b1;
                occ_nxt  = occ_inc[7:0];
              end
            end
            lpht_pkg::OP_REMOVE: begin
              if (found_r) begin
                st_we    = 1'b1;
                st_wdata = lpht_pkg::ST_TOMB;
              end
            end
            default: begin
              out_data_nxt.hit = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      clr_idx_r   <= '0;
      occ_r       <= '0;
      limit_r     <= lpht_pkg::LOAD_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Request and probe payload.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    idx_r        <= idx_nxt;
    steps_r      <= steps_nxt;
    tomb_seen_r  <= tomb_seen_nxt;
    tomb_idx_r   <= tomb_idx_nxt;
    found_r      <= found_nxt;
    where_r      <= where_nxt;
    where_ok_r   <= where_ok_nxt;
    where_tomb_r <= where_tomb_nxt;
    hit_val_r    <= hit_val_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Slot memories: one write port, one registered read of the next probe slot.
  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[wr_addr] <= st_wdata;
    end
    if (key_we) begin
      key_mem[wr_addr] <= cur_key;
    end
    if (val_we) begin
      value_mem[wr_addr] <= cur_val;
    end
    st_rd_r  <= status_mem[idx_nxt];
    key_rd_r <= key_mem[idx_nxt];
    val_rd_r <= value_mem[idx_nxt];
  end

  assign clearing  = (state_r == BS_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The occupied count only grows; removals leave tombstones.
  `LPHT_ASSERT_NXT(a_occ_grows, 1'b1, occ_r >= $past(occ_r))
  // No request leaves the queue while the status memory is being cleared.
  `LPHT_ASSERT_IMP(a_no_pop_clear, state_r == BS_CLEAR, !pop_req)
  // A new result only appears after a commit.
  `LPHT_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == BS_DONE)
  // A commit with a free result register always delivers.
  `LPHT_ASSERT_NXT(a_done_emits, (state_r == BS_DONE) && !out_valid_r,
                   out_valid_r && (state_r == BS_IDLE))

endmodule

FILE: rtl/linear_probe_hash_table_core.sv
// Linear probe hash table: top level joining front end, request queue and back end.
//
// Open-addressing key/value table with linear probing and tombstones. Each get, set or
// remove returns one result. After reset the slot status memory is cleared one slot a
// cycle, and no request is taken until that pass ends; the load limit can be written
// meanwhile. The front end takes a request every cycle while the queue has room, and
// reduces the hash to a home slot through a registered product and a registered home
// slot. The back end serves one request at a time: it takes it from the queue, probes
// one slot a cycle (each slot is one registered read of the status, key and value
// memories), then commits and loads the result register once that register is free;
// the unused opcode skips the probe.
module linear_probe_hash_table_core #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  logic               clearing;
  logic               front_valid;
  logic               front_stall;
  logic               push_valid;
  lpht_pkg::q_entry_t push_data;
  logic               push_stall;
  logic               pop_valid;
  lpht_pkg::q_entry_t pop_data;
  logic               pop_req;

  // Hold off input transfers during the clearing pass.
  assign front_valid = in_valid && !clearing;
  assign in_stall    = front_stall || clearing;

  lpht_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (front_valid),
    .in_data    (in_data),
    .in_stall   (front_stall),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_stall (push_stall)
  );

  lpht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_stall (push_stall),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_req    (pop_req)
  );

  lpht_back #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pop_valid   (pop_valid),
    .pop_data    (pop_data),
    .pop_req     (pop_req),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: tb/tb_linear_probe_hash_table_core.sv
// Self-checking testbench for the linear probe hash table core.
module tb_linear_probe_hash_table_core;

  localparam int SLOTS = lpht_pkg::SLOTS_DEF;
  localparam logic [31:0] HOME_MASK = SLOTS - 1;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_KEYS = 48;
  localparam int PHASE_ITEMS = 332;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lpht_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lpht_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  // Mirror of the table contents and its load limit.
  logic [1:0] slot_state [SLOTS];
  logic [31:0] slot_key_m [SLOTS];
  logic [63:0] slot_val_m [SLOTS];
  int occ_cnt = 0;
  int load_lim = lpht_pkg::LOAD_LIMIT_RST;

  // Requests waiting to be offered and results still owed by the table.
  lpht_pkg::in_item_t pending_reqs [$];
  lpht_pkg::out_item_t expected_results [$];
  lpht_pkg::out_item_t want;

  // Keys with fixed hashes, clustered so that probe chains grow and wrap.
  logic [31:0] pool_key [POOL_KEYS];
  logic [31:0] pool_hash [POOL_KEYS];

  int queued_total = 0;
  int accepted_total = 0;
  int matched_total = 0;
  int errors = 0;
  int n_hits = 0;
  int n_refused = 0;
  int n_reused = 0;
  int peak_occ = 0;
  longint cycle_count = 0;

  // Pacing of both channels, set between phases.
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit pressure_req = 1'b0;
  bit pressure_taken = 1'b0;
  int hold_left = 0;

  linear_probe_hash_table_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Apply one request to the mirror and return the result the table owes for it.
  function automatic lpht_pkg::out_item_t table_apply(lpht_pkg::in_item_t req);
    lpht_pkg::out_item_t res;
    int idx;
    int n;
    int tomb_idx;
    int where_idx;
    bit tomb_seen;
    bit found;
    bit where_ok;
    res = '0;
    if (req.opcode == OP_UNUSED) return res;
    idx = int'(req.key_hash % SLOTS);
    tomb_idx = 0;
    where_idx = 0;
    tomb_seen = 1'b0;
    found = 1'b0;
    where_ok = 1'b0;
    // Walk from the home slot until the key, an empty slot, or a full lap.
    for (n = 0; n < SLOTS; n++) begin
      if (slot_state[idx] == lpht_pkg::ST_EMPTY) begin
        where_idx = tomb_seen ? tomb_idx : idx;
        where_ok = 1'b1;
        break;
      end
      if (slot_state[idx] == lpht_pkg::ST_LIVE) begin
        if (slot_key_m[idx] == req.key_id) begin
          found = 1'b1;
          where_idx = idx;
          where_ok = 1'b1;
          break;
        end
      end else if (!tomb_seen) begin
        tomb_seen = 1'b1;
        tomb_idx = idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    // A lap without an empty slot can still insert at the first tombstone.
    if (!where_ok && tomb_seen) begin
      where_idx = tomb_idx;
      where_ok = 1'b1;
    end
    res.hit = found;
    if (found) n_hits++;
    case (req.opcode)
      lpht_pkg::OP_GET: begin
        if (found) res.value_out = slot_val_m[where_idx];
      end
      lpht_pkg::OP_SET: begin
        if (found) begin
          slot_val_m[where_idx] = req.value_in;
        end else if (!where_ok) begin
          res.full_res = 1'b1;
        end else if (slot_state[where_idx] == lpht_pkg::ST_TOMB) begin
          // Reusing a tombstone leaves the occupied count alone.
          slot_state[where_idx] = lpht_pkg::ST_LIVE;
          slot_key_m[where_idx] = req.key_id;
          slot_val_m[where_idx] = req.value_in;
          n_reused++;
        end else if (occ_cnt + 1 > load_lim) begin
          res.full_res = 1'b1;
        end else begin
          slot_state[where_idx] = lpht_pkg::ST_LIVE;
          slot_key_m[where_idx] = req.key_id;
          slot_val_m[where_idx] = req.value_in;
          occ_cnt++;
          if (occ_cnt > peak_occ) peak_occ = occ_cnt;
        end
      end
      lpht_pkg::OP_REMOVE: begin
        if (found) slot_state[where_idx] = lpht_pkg::ST_TOMB;
      end
      default: begin
      end
    endcase
    if (res.full_res) n_refused++;
    return res;
  endfunction

  // Request side: offer queued requests and hold a stalled transfer steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(table_apply(in_data));
        accepted_total++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each transfer against the oldest expectation and pace the stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display({"%0t: result with nothing expected, expected none, ",
                    "actual hit=%0b value=%h full=%0b"},
                   $time, out_data.hit, out_data.value_out, out_data.full_res);
          errors++;
        end else begin
          want = expected_results.pop_front();
          matched_total++;
          if (out_data.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want.hit, out_data.hit);
            errors++;
          end
          if (out_data.value_out !== want.value_out) begin
            $display("%0t: value_out mismatch, expected %h, actual %h",
                     $time, want.value_out, out_data.value_out);
            errors++;
          end
          if (out_data.full_res !== want.full_res) begin
            $display("%0t: full_res mismatch, expected %0b, actual %0b",
                     $time, want.full_res, out_data.full_res);
            errors++;
          end
        end
      end
      // A requested hold-off stalls the result channel for a long stretch.
      if (pressure_req && !pressure_taken) begin
        hold_left = HOLD_CYCLES;
        pressure_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_linear_probe_hash_table_core: errors");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] op, input logic [31:0] key,
                          input logic [31:0] hash, input logic [63:0] val);
    lpht_pkg::in_item_t req;
    req.opcode = op;
    req.key_id = key;
    req.key_hash = hash;
    req.value_in = val;
    pending_reqs.push_back(req);
    queued_total++;
  endtask

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return lpht_pkg::OP_GET;
    if (r < 75) return lpht_pkg::OP_SET;
    return lpht_pkg::OP_REMOVE;
  endfunction

  // Mostly pool keys with consistent hashes; some fresh keys and unused opcodes.
  task automatic push_random_req();
    int r;
    int pick;
    logic [63:0] val;
    val = {$urandom, $urandom};
    r = $urandom_range(99);
    pick = $urandom_range(POOL_KEYS - 1);
    if (r < 4) begin
      push_req(OP_UNUSED, $urandom, $urandom, val);
    end else if (r < 12) begin
      push_req(pick_op(), $urandom, $urandom, val);
    end else begin
      push_req(pick_op(), pool_key[pick], pool_hash[pick], val);
    end
  endtask

  task automatic wait_table_idle();
    wait (accepted_total == queued_total && matched_total == queued_total);
    @(posedge clk);
  endtask

  task automatic write_load_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    load_lim = v;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] limit,
                           input bit hold_off);
    int i;
    write_load_limit(limit);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    if (hold_off) pressure_req = 1'b1;
    for (i = 0; i < PHASE_ITEMS; i++) push_random_req();
    wait_table_idle();
  endtask

  initial begin
    int i;
    int home;
    int lim;
    for (i = 0; i < SLOTS; i++) begin
      slot_state[i] = lpht_pkg::ST_EMPTY;
      slot_key_m[i] = '0;
      slot_val_m[i] = '0;
    end
    for (i = 0; i < POOL_KEYS; i++) begin
      case ($urandom_range(3))
        0: home = $urandom_range(3);
        1: home = 100 + $urandom_range(1);
        2: home = SLOTS - 1 - $urandom_range(5);
        default: home = $urandom_range(SLOTS - 1);
      endcase
      pool_key[i] = $urandom;
      pool_hash[i] = ($urandom & ~HOME_MASK) | 32'(home);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Basic life cycle of a key, collisions, tombstones and wrap at the table end.
    push_req(lpht_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(lpht_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(lpht_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 64'h0);
    push_req(lpht_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 64'h0);
    push_req(lpht_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 64'h1);
    push_req(lpht_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 64'h5A5A_A5A5_0F0F_F0F0);
    push_req(lpht_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 64'h0);
    push_req(lpht_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 64'h0);
    push_req(lpht_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 64'h0);
    push_req(lpht_pkg::OP_SET, 32'h1234_5678, 32'h0000_0100, 64'h1111_2222_3333_4444);
    push_req(lpht_pkg::OP_GET, 32'h1234_5678, 32'h0000_0100, 64'h0);
    push_req(lpht_pkg::OP_SET, 32'hA5A5_0001, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
    push_req(lpht_pkg::OP_SET, 32'h5A5A_0002, 32'h1357_9BFF, 64'h7FFF_FFFF_FFFF_FFFE);
    push_req(lpht_pkg::OP_GET, 32'h5A5A_0002, 32'h1357_9BFF, 64'h0);
    push_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(lpht_pkg::OP_GET, 32'h3C3C_0005, 32'hFFFF_FFFF, 64'h0);
    wait_table_idle();

    // With no room allowed, new keys are refused but updates and tombstone reuse still work.
    write_load_limit(8'd0);
    push_req(lpht_pkg::OP_SET, 32'h0BAD_0003, 32'h0000_0010, 64'hDEAD_BEEF_0000_0001);
    push_req(lpht_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
    push_req(lpht_pkg::OP_REMOVE, 32'hA5A5_0001, 32'hFFFF_FFFF, 64'h0);
    push_req(lpht_pkg::OP_SET, 32'h7777_0004, 32'h0000_00FF, 64'hCAFE_0000_0000_0002);
    push_req(lpht_pkg::OP_GET, 32'h5A5A_0002, 32'h1357_9BFF, 64'h0);
    wait_table_idle();

    write_load_limit(8'd1);
    push_req(lpht_pkg::OP_SET, 32'h0BAD_0003, 32'h0000_0010, 64'hDEAD_BEEF_0000_0003);
    push_req(lpht_pkg::OP_GET, 32'h0BAD_0003, 32'h0000_0010, 64'h0);
    wait_table_idle();

    // Random phases over several load limits and pacing modes.
    lim = (occ_cnt + 6 > 255) ? 255 : occ_cnt + 6;
    run_phase(0, 0, 8'(lim), 1'b0);
    lim = (occ_cnt + 60 > 254) ? 254 : occ_cnt + 60;
    run_phase(69, 0, 8'(lim), 1'b0);
    run_phase(0, 69, 8'd255, 1'b1);
    run_phase(36, 36, 8'd1, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests: %0d hits, %0d refused sets, %0d tombstone reuses.",
             queued_total, n_hits, n_refused, n_reused);
    $display({"Load limits from 0 to 255, peak occupancy %0d, ",
              "four pacing modes and one long stall."},
             peak_occ);
    if (errors == 0) begin
      $display("tb_linear_probe_hash_table_core: clean");
    end else begin
      $display("tb_linear_probe_hash_table_core: errors");
    end
    $finish;
  end

endmodule
